[design/bavg_pkg.sv]
// Shared types, constants and divide helpers for the block average downscaler.
package bavg_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_FACTOR  = 16;
    localparam int SUM_COLUMNS = 2048;

    localparam int DIM_W  = 13;                      // image_width / image_height
    localparam int FAC_W  = 5;                       // block_factor
    localparam int HALF_W = 4;                       // block_factor / 2
    localparam int COL_W  = $clog2(MAX_WIDTH);       // pixel column
    localparam int ROW_W  = $clog2(MAX_HEIGHT);      // pixel row
    localparam int BLK_W  = 4;                       // position inside a block
    localparam int OCOL_W = $clog2(SUM_COLUMNS);     // output column, RAM address
    localparam int OUTW_W = OCOL_W + 1;              // output columns, up to SUM_COLUMNS
    localparam int SUM_W  = 16;                      // one channel sum
    localparam int ENTRY_W = 3 * SUM_W;              // packed red, green, blue sums
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int SETTLE_W   = 2;

    localparam logic [OCOL_W-1:0]   OUT_COL_MAX   = OCOL_W'(SUM_COLUMNS - 1);
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    typedef enum logic [1:0] {
        S_SETTLE,
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;   // take the input beat and start the sum read
        logic step;     // update the sums and advance the counters
        logic load;     // divide and load the output register
    } t_cmd;

    typedef struct packed {
        logic emit;     // the current pixel closes a block
        logic out_free; // the output register can take a beat this cycle
    } t_status;

    // floor(v / k) for k in 1..8 by a reciprocal multiply; exact for 12-bit v.
    function automatic logic [11:0] dim_div(input logic [11:0] v, input logic [HALF_W-1:0] k);
        logic [20:0] m;
        logic [32:0] p;
        case (k)
            4'd1:    m = 21'd1048576;
            4'd2:    m = 21'd524288;
            4'd3:    m = 21'd349526;
            4'd4:    m = 21'd262144;
            4'd5:    m = 21'd209716;
            4'd6:    m = 21'd174763;
            4'd7:    m = 21'd149797;
            4'd8:    m = 21'd131072;
            default: m = 21'd0;
        endcase
        p = 33'(v) * 33'(m);
        return p[31:20];
    endfunction

    // Low byte of floor(v / k^2) for k in 1..8; exact for 14-bit v.
    function automatic logic [7:0] avg_div(input logic [13:0] v, input logic [HALF_W-1:0] k);
        logic [26:0] m;
        logic [40:0] p;
        case (k)
            4'd1:    m = 27'd67108864;
            4'd2:    m = 27'd16777216;
            4'd3:    m = 27'd7456541;
            4'd4:    m = 27'd4194304;
            4'd5:    m = 27'd2684355;
            4'd6:    m = 27'd1864136;
            4'd7:    m = 27'd1369569;
            4'd8:    m = 27'd1048576;
            default: m = 27'd0;
        endcase
        p = 41'(v) * 41'(m);
        return p[33:26];
    endfunction

endpackage

[design/bavg_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bavg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bavg_ctrl.sv]
// Controller state machine: sequences accept, sum update and result load.
module bavg_ctrl import bavg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_cfg_we,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    t_state              r_state, n_state;
    logic [SETTLE_W-1:0] r_settle, n_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SETTLE;
            r_settle <= SETTLE_CYCLES;
        end else begin
            r_state  <= n_state;
            r_settle <= n_settle;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_settle = r_settle;
        o_cmd    = '0;
        unique case (r_state)
            S_SETTLE: begin
                if (i_cfg_we) begin
                    n_settle = SETTLE_CYCLES;
                end else if (r_settle == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_settle = r_settle - 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CALC;
                end else if (i_cfg_we) begin
                    n_settle = SETTLE_CYCLES;
                    n_state  = S_SETTLE;
                end
            end
            S_CALC: begin
                o_cmd.step = 1'b1;
                n_state    = i_status.emit ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // An accepted beat always goes straight to the sum update.
    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_CALC))
        else $error("accepted beat did not proceed to the update state");

    // A result is only pending after an update that closed a block.
    a_emit_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ($past(r_state) == S_CALC || $past(r_state) == S_EMIT))
        else $error("emit state entered without a block update");

endmodule

[design/bavg_dp.sv]
// Datapath: configuration, position counters, column sums and output register.
module bavg_dp import bavg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_start_of_frame,
    input  logic [7:0]            i_chan_red,
    input  logic [7:0]            i_chan_green,
    input  logic [7:0]            i_chan_blue,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [7:0]            o_avg_red,
    output logic [7:0]            o_avg_green,
    output logic [7:0]            o_avg_blue,
    output logic                  o_row_done
);

    // Configuration registers.
    logic [FAC_W-1:0] r_factor;
    logic             r_gray;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= 5'd2;
            r_gray   <= 1'b1;
            r_width  <= 13'd640;
            r_height <= 13'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BLOCK_FACTOR: r_factor <= i_cfg_data[FAC_W-1:0];
                REG_GRAY_MODE:    r_gray   <= i_cfg_data[0];
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
            endcase
        end
    end

    // Derived limits, recomputed every cycle in two registered stages.
    logic [DIM_W-1:0]  n_w, n_h;
    logic [11:0]       n_qw, n_qh;
    logic [OUTW_W-1:0] n_outw;
    logic              n_fvalid;
    logic [16:0]       rows_prod;

    logic              r_fvalid;
    logic [FAC_W-1:0]  r_f;
    logic [HALF_W-1:0] r_k;
    logic [DIM_W-1:0]  r_w, r_h;
    logic [OUTW_W-1:0] r_outw;
    logic [11:0]       r_outh;
    logic [DIM_W-1:0]  r_rows_lim;

    always_comb begin
        n_fvalid = (r_factor >= 5'd2) && (r_factor <= FAC_W'(MAX_FACTOR)) && !r_factor[0];
        if (r_width > DIM_W'(MAX_WIDTH)) begin
            n_w = DIM_W'(MAX_WIDTH);
        end else if (r_width == '0) begin
            n_w = 13'd1;
        end else begin
            n_w = r_width;
        end
        if (r_height > DIM_W'(MAX_HEIGHT)) begin
            n_h = DIM_W'(MAX_HEIGHT);
        end else if (r_height == '0) begin
            n_h = 13'd1;
        end else begin
            n_h = r_height;
        end
        // The factor is even, so w / f is (w / 2) / (f / 2).
        n_qw = dim_div(n_w[DIM_W-1:1], r_factor[FAC_W-1:1]);
        n_qh = dim_div(n_h[DIM_W-1:1], r_factor[FAC_W-1:1]);
        if (n_qw > 12'(SUM_COLUMNS)) begin
            n_outw = OUTW_W'(SUM_COLUMNS);
        end else begin
            n_outw = n_qw[OUTW_W-1:0];
        end
        rows_prod = {5'b0, r_outh} * {12'b0, r_f};
    end

    always_ff @(posedge i_clk) begin
        r_fvalid   <= n_fvalid;
        r_f        <= r_factor;
        r_k        <= r_factor[FAC_W-1:1];
        r_w        <= n_w;
        r_h        <= n_h;
        r_outw     <= n_outw;
        r_outh     <= n_qh;
        r_rows_lim <= rows_prod[DIM_W-1:0];
    end

    // Captured pixel.
    logic [7:0] r_pix_r, r_pix_g, r_pix_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix_r <= i_chan_red;
            r_pix_g <= r_gray ? 8'd0 : i_chan_green;
            r_pix_b <= r_gray ? 8'd0 : i_chan_blue;
        end
    end

    // Position counters.
    logic [COL_W-1:0]  r_pc;
    logic [ROW_W-1:0]  r_pr;
    logic [BLK_W-1:0]  r_rib, r_cib;
    logic [OCOL_W-1:0] r_oc;

    logic pc_wrap, pr_wrap, rib_wrap, cib_wrap;

    assign pc_wrap  = ({1'b0, r_pc} + 13'd1) >= r_w;
    assign pr_wrap  = ({1'b0, r_pr} + 13'd1) >= r_h;
    assign rib_wrap = ({1'b0, r_rib} + 5'd1) >= r_f;
    assign cib_wrap = ({1'b0, r_cib} + 5'd1) >= r_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_pr  <= '0;
            r_rib <= '0;
            r_cib <= '0;
            r_oc  <= '0;
        end else if (i_cmd.accept && i_start_of_frame) begin
            r_pc  <= '0;
            r_pr  <= '0;
            r_rib <= '0;
            r_cib <= '0;
            r_oc  <= '0;
        end else if (i_cmd.step) begin
            if (pc_wrap) begin
                r_pc  <= '0;
                r_cib <= '0;
                r_oc  <= '0;
                if (pr_wrap) begin
                    r_pr  <= '0;
                    r_rib <= '0;
                end else begin
                    r_pr  <= r_pr + 1'b1;
                    r_rib <= (!r_fvalid || rib_wrap) ? '0 : r_rib + 1'b1;
                end
            end else begin
                r_pc <= r_pc + 1'b1;
                if (!r_fvalid) begin
                    r_cib <= '0;
                    r_oc  <= '0;
                end else if (cib_wrap) begin
                    r_cib <= '0;
                    if (r_oc < OUT_COL_MAX) begin
                        r_oc <= r_oc + 1'b1;
                    end
                end else begin
                    r_cib <= r_cib + 1'b1;
                end
            end
        end
    end

    // Column sums: read on accept, written back during the update.
    logic [ENTRY_W-1:0] ram_rdata, ram_wdata;
    logic [OCOL_W-1:0]  ram_raddr;
    logic               active, first_px, last_px, ram_we;
    logic [SUM_W-1:0]   sum_r, sum_g, sum_b;

    assign ram_raddr = i_start_of_frame ? '0 : r_oc;

    always_comb begin
        active   = r_fvalid && ({1'b0, r_oc} < r_outw) && ({1'b0, r_pr} < r_rows_lim)
                   && ({1'b0, r_cib} < r_f) && ({1'b0, r_rib} < r_f);
        first_px = (r_rib == '0) && (r_cib == '0);
        last_px  = ({1'b0, r_rib} == (r_f - 5'd1)) && ({1'b0, r_cib} == (r_f - 5'd1));
        if (first_px) begin
            sum_r = {8'd0, r_pix_r};
            sum_g = {8'd0, r_pix_g};
            sum_b = {8'd0, r_pix_b};
        end else begin
            sum_r = ram_rdata[SUM_W-1:0]         + {8'd0, r_pix_r};
            sum_g = ram_rdata[2*SUM_W-1:SUM_W]   + {8'd0, r_pix_g};
            sum_b = ram_rdata[3*SUM_W-1:2*SUM_W] + {8'd0, r_pix_b};
        end
        ram_wdata = {sum_b, sum_g, sum_r};
        ram_we    = i_cmd.step && active;
    end

    bavg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SUM_COLUMNS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_oc),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Finished block sums, held for the divide.
    logic [SUM_W-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic             r_last_col;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_sum_r    <= sum_r;
            r_sum_g    <= sum_g;
            r_sum_b    <= sum_b;
            r_last_col <= (({1'b0, r_oc} + 12'd1) == r_outw);
        end
    end

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_avg_r, r_avg_g, r_avg_b;
    logic       r_row_done;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sum / f^2 is (sum / 4) / (f / 2)^2.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_avg_r    <= avg_div(r_sum_r[SUM_W-1:2], r_k);
            r_avg_g    <= avg_div(r_sum_g[SUM_W-1:2], r_k);
            r_avg_b    <= avg_div(r_sum_b[SUM_W-1:2], r_k);
            r_row_done <= r_last_col;
        end
    end

    assign o_status.emit     = active && last_px;
    assign o_status.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_avg_red   = r_avg_r;
    assign o_avg_green = r_avg_g;
    assign o_avg_blue  = r_avg_b;
    assign o_row_done  = r_row_done;

    // A new result never overwrites one the receiver has not yet taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_valid || !i_out_stall))
        else $error("output register loaded over an untaken beat");

endmodule

[design/block_average_downscale_top.sv]
// Top level of the box-filter image downscaler.
//
// Pixels enter on the input channel in raster order, one beat per pixel, with
// start_of_frame raised on the first pixel of each image. Each beat carries a
// grey byte on chan_red, or an R,G,B triple when grey mode is off. For every
// complete block_factor by block_factor block one result beat leaves on the
// output channel, holding the truncated channel averages and a row_done flag
// on the last block of each output row. Partial edge blocks give no result.
//
// A pixel that closes no block is first accepted, with its column sum read
// from the sum RAM, and then its sum is updated. A pixel that closes a block
// takes a further step, in which the averages are formed by reciprocal
// multiplies and loaded into the output register once that register is free.
// The input is stalled until a pixel has gone through these steps, as the
// single sum RAM port pair is read then written once per pixel.
//
// After reset, and after a configuration write taken while idle with no
// pixel offered, the input is stalled in a settle state while the derived
// image limits are recomputed. The output register parts the two channels:
// while it holds a beat the receiver is stalling, further pixels are still
// taken, and only a new block result waits until the held beat has gone.
module block_average_downscale_top import bavg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_start_of_frame,
    input  logic [7:0]            i_chan_red,
    input  logic [7:0]            i_chan_green,
    input  logic [7:0]            i_chan_blue,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_avg_red,
    output logic [7:0]            o_avg_green,
    output logic [7:0]            o_avg_blue,
    output logic                  o_row_done
);

    // Command and status between the sequencer and the datapath.
    t_cmd    cmd;
    t_status status;

    bavg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_we   (i_cfg_we),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    bavg_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_start_of_frame (i_start_of_frame),
        .i_chan_red       (i_chan_red),
        .i_chan_green     (i_chan_green),
        .i_chan_blue      (i_chan_blue),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_avg_red        (o_avg_red),
        .o_avg_green      (o_avg_green),
        .o_avg_blue       (o_avg_blue),
        .o_row_done       (o_row_done)
    );

endmodule
